>>> sv/spifr_pkg.sv
`default_nettype none

package spifr_pkg;

  localparam int unsigned HdrBytes = 4;
  localparam logic [7:0] CmdMask = 8'h7F;

  localparam logic [15:0] MaxLenReset = 16'd1024;
  localparam logic [7:0] PolyReset = 8'h07;
  localparam logic [7:0] InitReset = 8'h00;

  typedef enum logic [1:0] {
    ReqSelect  = 2'd0,
    ReqByte    = 2'd1,
    ReqRelease = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    EvNeedMore = 3'd0,
    EvGood     = 3'd1,
    EvBadCrc   = 3'd2,
    EvTooLong  = 3'd3,
    EvIgnored  = 3'd4,
    EvSelect   = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    CfgMaxLen = 2'd0,
    CfgPoly   = 2'd1,
    CfgInit   = 2'd2
  } cfg_index_e;

  // One result as it leaves the block.
  typedef struct packed {
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [15:0] declared_length;
    logic [6:0]  command;
    event_e      event_code;
  } result_t;

  // MSB-first CRC-8 over one byte, implicit x^8 term.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/spi_frame_receiver_crc8.sv
// Length-prefixed SPI frame receiver with CRC-8 check. Each request is one SPI
// event (tuser: chip select asserted, data byte, chip select released) and gives
// exactly one result: an event code, the current command and declared length, and
// for payload bytes the byte with its index. A frame is a command byte (top bit
// dropped), a big-endian 16-bit length and a header CRC, then the payload; the
// MSB-first CRC-8 runs over the masked command, the length bytes and the payload.
// The block takes one request per clock: the frame state and the CRC are updated
// in the cycle a request is accepted, and the result sits in a two-entry output
// buffer, so input stalls only when both entries wait on the output side.
// Configuration writes are taken at once and are meant for idle periods only.
`default_nettype none

module spi_frame_receiver_crc8 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // Request stream.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] req_type
  // Result stream.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [6:0] command, [22:7] declared_length, [30:23] payload_byte,
  // [46:31] payload_index, [47] zero
  output logic [47:0]      m_axis_tdata_o,
  output logic [3:0]       m_axis_tuser_o   // [2:0] event_code, [3] payload_valid
);
  import spifr_pkg::*;

  logic [15:0] max_len_q;
  logic [7:0]  poly_q;
  logic [7:0]  crc_init_q;

  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic        done_q, done_d;
  logic [6:0]  cmd_q, cmd_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pay_cnt_q, pay_cnt_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  exp_crc_q, exp_crc_d;

  result_t     res;
  result_t     out_q, skid_q;
  logic        out_valid_q, skid_valid_q;

  logic        in_accept, out_fire;
  logic [7:0]  crc_in;
  logic [7:0]  crc_next;
  logic [15:0] pay_cnt_inc;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !skid_valid_q;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire        = out_valid_q && m_axis_tready_i;

  assign crc_in      = (hdr_cnt_q == 3'd0) ? (s_axis_tdata_i & CmdMask) : s_axis_tdata_i;
  assign crc_next    = crc8_step(crc_q, crc_in, poly_q);
  assign pay_cnt_inc = pay_cnt_q + 16'd1;

  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    done_d    = done_q;
    cmd_d     = cmd_q;
    len_hi_d  = len_hi_q;
    len_d     = len_q;
    pay_cnt_d = pay_cnt_q;
    crc_d     = crc_q;
    exp_crc_d = exp_crc_q;

    res            = '0;
    res.event_code = EvIgnored;

    case (s_axis_tuser_i)
      ReqSelect: begin
        hdr_cnt_d      = '0;
        done_d         = 1'b0;
        cmd_d          = '0;
        len_hi_d       = '0;
        len_d          = '0;
        pay_cnt_d      = '0;
        crc_d          = crc_init_q;
        exp_crc_d      = '0;
        res.event_code = EvSelect;
      end
      ReqRelease: begin
        done_d         = 1'b1;
        hdr_cnt_d      = '0;
        res.event_code = EvSelect;
      end
      ReqByte: begin
        if (!done_q) begin
          res.event_code = EvNeedMore;
          if (hdr_cnt_q < 3'(HdrBytes)) begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
            case (hdr_cnt_q)
              3'd0: begin
                cmd_d = s_axis_tdata_i[6:0];
                crc_d = crc_next;
              end
              3'd1: begin
                len_hi_d = s_axis_tdata_i;
                crc_d    = crc_next;
              end
              3'd2: begin
                len_d = {len_hi_q, s_axis_tdata_i};
                crc_d = crc_next;
              end
              default: begin
                exp_crc_d = s_axis_tdata_i;
                pay_cnt_d = '0;
                if (len_q > max_len_q) begin
                  done_d         = 1'b1;
                  res.event_code = EvTooLong;
                end else if (len_q == '0) begin
                  done_d         = 1'b1;
                  res.event_code = (crc_q == s_axis_tdata_i) ? EvGood : EvBadCrc;
                end
              end
            endcase
          end else begin
            if (pay_cnt_q < len_q) begin
              res.payload_valid = 1'b1;
              res.payload_byte  = s_axis_tdata_i;
              res.payload_index = pay_cnt_q;
              crc_d             = crc_next;
              pay_cnt_d         = pay_cnt_inc;
            end
            if (pay_cnt_d >= len_q) begin
              done_d         = 1'b1;
              res.event_code = (crc_d == exp_crc_q) ? EvGood : EvBadCrc;
            end
          end
        end
      end
      default: begin
      end
    endcase

    res.command         = cmd_d;
    res.declared_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= MaxLenReset;
      poly_q     <= PolyReset;
      crc_init_q <= InitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgMaxLen: max_len_q  <= cfg_data_i;
        CfgPoly:   poly_q     <= cfg_data_i[7:0];
        CfgInit:   crc_init_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      done_q    <= 1'b0;
      cmd_q     <= '0;
      len_hi_q  <= '0;
      len_q     <= '0;
      pay_cnt_q <= '0;
      crc_q     <= InitReset;
      exp_crc_q <= '0;
    end else if (in_accept) begin
      hdr_cnt_q <= hdr_cnt_d;
      done_q    <= done_d;
      cmd_q     <= cmd_d;
      len_hi_q  <= len_hi_d;
      len_q     <= len_d;
      pay_cnt_q <= pay_cnt_d;
      crc_q     <= crc_d;
      exp_crc_q <= exp_crc_d;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.payload_index, out_q.payload_byte,
                            out_q.declared_length, out_q.command};
  assign m_axis_tuser_o  = {out_q.payload_valid, out_q.event_code};

endmodule

`default_nettype wire

>>> sim/spi_frame_receiver_crc8_test.sv
`timescale 1ns / 100ps

module spi_frame_receiver_crc8_test;
  import spifr_pkg::*;

  localparam logic [1:0] ReqUnknown = 2'd3;

  class frame_scoreboard;
    logic [15:0] max_len = MaxLenReset;
    logic [7:0]  poly = PolyReset;
    logic [7:0]  crc_initial = InitReset;

    logic [2:0]  hdr_count;
    bit          frame_closed;
    logic [6:0]  cmd_code;
    logic [7:0]  len_high;
    logic [15:0] frame_len;
    logic [15:0] bytes_taken;
    logic [7:0]  crc_acc;
    logic [7:0]  hdr_crc;

    result_t expected_results[$];
    int unsigned mismatches = 0;

    function new();
      restart_frame();
    endfunction

    function void restart_frame();
      hdr_count = '0;
      frame_closed = 1'b0;
      cmd_code = '0;
      len_high = '0;
      frame_len = '0;
      bytes_taken = '0;
      crc_acc = crc_initial;
      hdr_crc = '0;
    endfunction

    function logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b);
      logic [7:0] acc;
      acc = crc ^ b;
      repeat (8) acc = acc[7] ? ((acc << 1) ^ poly) : (acc << 1);
      return acc;
    endfunction

    function void set_register(cfg_index_e idx, logic [15:0] value);
      case (idx)
        CfgMaxLen: max_len = value;
        CfgPoly:   poly = value[7:0];
        CfgInit:   crc_initial = value[7:0];
        default:   ;
      endcase
    endfunction

    function event_e crc_verdict();
      return (crc_acc == hdr_crc) ? EvGood : EvBadCrc;
    endfunction

    // Advances the frame state for one accepted request and queues its result.
    function event_e note_request(logic [1:0] req, logic [7:0] b);
      result_t r;
      r = '0;
      r.event_code = EvIgnored;
      case (req)
        ReqSelect: begin
          restart_frame();
          r.event_code = EvSelect;
        end
        ReqRelease: begin
          frame_closed = 1'b1;
          hdr_count = '0;
          r.event_code = EvSelect;
        end
        ReqByte: begin
          if (!frame_closed && hdr_count < HdrBytes) begin
            r.event_code = EvNeedMore;
            case (hdr_count)
              3'd0: begin
                cmd_code = b[6:0];
                crc_acc = crc_byte(crc_acc, {1'b0, b[6:0]});
              end
              3'd1: begin
                len_high = b;
                crc_acc = crc_byte(crc_acc, b);
              end
              3'd2: begin
                frame_len = {len_high, b};
                crc_acc = crc_byte(crc_acc, b);
              end
              default: begin
                hdr_crc = b;
                bytes_taken = '0;
                if (frame_len > max_len) begin
                  frame_closed = 1'b1;
                  r.event_code = EvTooLong;
                end else if (frame_len == 0) begin
                  frame_closed = 1'b1;
                  r.event_code = crc_verdict();
                end
              end
            endcase
            hdr_count = hdr_count + 3'd1;
          end else if (!frame_closed) begin
            r.event_code = EvNeedMore;
            if (bytes_taken < frame_len) begin
              r.payload_valid = 1'b1;
              r.payload_byte = b;
              r.payload_index = bytes_taken;
              crc_acc = crc_byte(crc_acc, b);
              bytes_taken = bytes_taken + 16'd1;
            end
            if (bytes_taken >= frame_len) begin
              frame_closed = 1'b1;
              r.event_code = crc_verdict();
            end
          end
        end
        default: ;
      endcase
      r.command = cmd_code;
      r.declared_length = frame_len;
      expected_results.push_back(r);
      return r.event_code;
    endfunction

    task report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      mismatches++;
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    endtask

    task check_result(logic [47:0] data, logic [3:0] user);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending", data[15:0], 16'h0);
        return;
      end
      want = expected_results.pop_front();
      if (user[2:0] != want.event_code)
        report_mismatch("event_code", user[2:0], want.event_code);
      if (data[6:0] != want.command)
        report_mismatch("command", data[6:0], want.command);
      if (data[22:7] != want.declared_length)
        report_mismatch("declared_length", data[22:7], want.declared_length);
      if (user[3] != want.payload_valid)
        report_mismatch("payload_valid", user[3], want.payload_valid);
      if (data[30:23] != want.payload_byte)
        report_mismatch("payload_byte", data[30:23], want.payload_byte);
      if (data[46:31] != want.payload_index)
        report_mismatch("payload_index", data[46:31], want.payload_index);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;

  frame_scoreboard sb = new();
  bit sender_idle = 1'b1;
  bit sink_idle = 1'b1;
  bit hold_request = 1'b0;
  int unsigned requests_sent = 0;

  spi_frame_receiver_crc8 dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready_i <= 1'b0;
        repeat (80) @(posedge clk_i);
        hold_request = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_request(input logic [1:0] req, input logic [7:0] b);
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= req;
    s_axis_tdata_i <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (sb.note_request(req, b) != EvIgnored) requests_sent++;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input logic [7:0] payload[$], input bit spoil_crc,
                            input bit with_select);
    logic [7:0] crc;
    crc = sb.crc_initial;
    crc = sb.crc_byte(crc, {1'b0, cmd[6:0]});
    crc = sb.crc_byte(crc, len[15:8]);
    crc = sb.crc_byte(crc, len[7:0]);
    foreach (payload[i]) begin
      if (i < len) crc = sb.crc_byte(crc, payload[i]);
    end
    if (spoil_crc) crc = crc ^ (8'h01 << $urandom_range(0, 7));
    if (with_select) send_request(ReqSelect, 8'($urandom_range(0, 255)));
    send_request(ReqByte, cmd);
    send_request(ReqByte, len[15:8]);
    send_request(ReqByte, len[7:0]);
    send_request(ReqByte, crc);
    foreach (payload[i]) send_request(ReqByte, payload[i]);
  endtask

  task automatic random_frame();
    logic [7:0]  body[$];
    logic [15:0] len;
    int unsigned pick, count;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      len = '0;
    end else if (pick == 1 && sb.max_len != 16'hFFFF) begin
      len = 16'($urandom_range(int'(sb.max_len) + 1, 65535));
    end else if (pick == 2 && sb.max_len <= 200) begin
      len = sb.max_len;
    end else begin
      len = 16'($urandom_range(1, 12));
    end
    if (len > sb.max_len) begin
      count = $urandom_range(0, 2);
    end else if ($urandom_range(0, 9) == 0) begin
      count = $urandom_range(0, len);
    end else begin
      count = len;
    end
    repeat (count) body.push_back(8'($urandom_range(0, 255)));
    send_frame(8'($urandom_range(0, 255)), len, body, $urandom_range(0, 7) == 0,
               $urandom_range(0, 15) != 0);
    case ($urandom_range(0, 5))
      0: send_request(ReqByte, 8'($urandom_range(0, 255)));
      1: send_request(ReqUnknown, 8'($urandom_range(0, 255)));
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) send_request(ReqRelease, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_index_e idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [15:0] max_lens[6];
    logic [7:0]  polys[6];
    logic [7:0]  inits[6];
    logic [7:0]  bytes[$];
    int unsigned target;
    max_lens = '{16'd1024, 16'd0, 16'hFFFF, 16'd16, 16'($urandom_range(4, 40)), 16'd200};
    polys = '{8'h07, 8'hFF, 8'h00, 8'h31, 8'($urandom_range(0, 255)), 8'h9B};
    inits = '{8'h00, 8'hFF, 8'h5A, 8'hFF, 8'($urandom_range(0, 255)), 8'h00};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The receiver is live right after reset, so a frame without a select is taken.
    send_frame(8'h85, 16'h0000, bytes, 1'b0, 1'b0);
    send_request(ReqByte, 8'hFF);
    send_request(ReqUnknown, 8'hAA);
    send_request(ReqRelease, 8'h00);
    bytes = '{8'h00, 8'hFF, 8'h5A};
    send_frame(8'hFF, 16'd3, bytes, 1'b0, 1'b1);
    bytes.delete();
    send_frame(8'h00, 16'hFFFF, bytes, 1'b0, 1'b1);
    send_request(ReqByte, 8'h3C);
    bytes = '{8'hFF};
    send_frame(8'h7F, 16'd1, bytes, 1'b1, 1'b1);
    bytes.delete();
    send_frame(8'h12, 16'd0, bytes, 1'b1, 1'b1);
    send_request(ReqSelect, 8'hFF);
    send_request(ReqByte, 8'h01);
    send_request(ReqRelease, 8'hFF);
    send_request(ReqByte, 8'h55);

    // Hold the result side off while a long frame streams in.
    sender_idle = 1'b0;
    hold_request = 1'b1;
    repeat (30) bytes.push_back(8'($urandom_range(0, 255)));
    send_frame(8'($urandom_range(0, 255)), 16'd30, bytes, 1'b0, 1'b1);
    sender_idle = 1'b1;

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_register(CfgMaxLen, max_lens[p]);
      write_register(CfgPoly, {8'h00, polys[p]});
      write_register(CfgInit, {8'h00, inits[p]});
      if (p == 5) begin
        sender_idle = 1'b0;
        sink_idle = 1'b0;
      end
      target = requests_sent + 300;
      while (requests_sent < target) random_frame();
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
sv/spifr_pkg.sv
sv/spi_frame_receiver_crc8.sv
sim/spi_frame_receiver_crc8_test.sv
